// ===== design/lpm_pkg.sv =====
package lpm_pkg;

    localparam int TableDepth = 16;
    localparam int NumIfaces = 4;
    localparam logic [15:0] ImplicitMetric = 16'd30;
    localparam int RegIndexW = 3;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_DEL = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_SET_NH = 3'd3,
        OP_SET_IF = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_EXISTS = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL = 3'd3,
        ST_BAD_IFACE = 3'd4
    } t_status;

    localparam logic [RegIndexW-1:0] REG_IFACE0 = 3'd0;
    localparam logic [RegIndexW-1:0] REG_IFACE1 = 3'd1;
    localparam logic [RegIndexW-1:0] REG_IFACE2 = 3'd2;
    localparam logic [RegIndexW-1:0] REG_IFACE3 = 3'd3;
    localparam logic [RegIndexW-1:0] REG_PREFIXES = 3'd4;
    localparam logic [RegIndexW-1:0] REG_ENABLES = 3'd5;

    typedef struct packed {
        logic [2:0] opcode;
        logic [31:0] address;
        logic [5:0] prefix_len;
        logic [15:0] metric;
        logic [31:0] next_hop;
        logic iface_given;
        logic [1:0] iface_index;
        logic [15:0] route_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic found;
        logic implicit;
        logic [15:0] result_id;
        logic [31:0] result_next_hop;
        logic result_has_iface;
        logic [1:0] result_iface;
        logic [5:0] result_prefix;
        logic [15:0] result_metric;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_IFSCAN,
        S_FINISH,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic if_clear;
        logic if_step;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic if_last;
        logic need_ifscan;
        logic no_result;
    } t_sts;

    function automatic logic [5:0] sat_prefix(input logic [5:0] p);
        return (p > 6'd32) ? 6'd32 : p;
    endfunction

    function automatic logic [31:0] prefix_mask(input logic [5:0] p);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++) begin
            if (32 - b <= int'(p)) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== design/lpm_ctrl.sv =====
module lpm_ctrl (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_out_stall,
    input lpm_pkg::t_sts i_sts,
    output logic o_in_stall,
    output logic o_valid,
    output lpm_pkg::t_cmd o_cmd
);
    import lpm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.if_clear = 1'b1;
                    n_state = S_IFSCAN;
                end
            end
            S_IFSCAN: begin
                if (i_sts.need_ifscan) begin
                    o_cmd.if_step = 1'b1;
                    if (i_sts.if_last) begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = i_sts.no_result ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/lpm_dp.sv =====
module lpm_dp #(
    parameter int TABLE_DEPTH = lpm_pkg::TableDepth,
    parameter int NUM_IFACES = lpm_pkg::NumIfaces
) (
    input logic i_clk,
    input logic i_rst_n,
    input lpm_pkg::t_in_item i_item,
    input logic i_cfg_we,
    input logic [lpm_pkg::RegIndexW-1:0] i_cfg_index,
    input logic [31:0] i_cfg_data,
    input lpm_pkg::t_cmd i_cmd,
    output lpm_pkg::t_sts o_sts,
    output lpm_pkg::t_out_item o_item
);
    import lpm_pkg::*;

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Per-entry storage in flip-flops, read at the scan index and at the selected result index.
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [31:0] r_net [TABLE_DEPTH];
    logic [5:0] r_pfx [TABLE_DEPTH];
    logic [15:0] r_met [TABLE_DEPTH];
    logic [31:0] r_nh [TABLE_DEPTH];
    logic r_bnd [TABLE_DEPTH];
    logic [1:0] r_ifc [TABLE_DEPTH];
    logic [15:0] r_id [TABLE_DEPTH];
    logic [15:0] r_next_id;

    logic [31:0] r_if_addr [4];
    logic [23:0] r_if_pfx;
    logic [3:0] r_if_en;

    t_in_item r_in;
    logic [31:0] r_net_in;
    logic [5:0] r_p_in;
    logic [IdxW-1:0] r_k;
    logic [1:0] r_i;

    logic r_ex_hit, r_id_hit, r_free_hit, r_best_hit, r_if_hit;
    logic [IdxW-1:0] r_ex_k, r_id_k, r_free_k, r_best_k;
    logic [5:0] r_best_p, r_if_p;
    logic [15:0] r_best_m, r_best_id;
    logic [1:0] r_if_best;
    t_out_item r_out;

    logic [31:0] e_net;
    logic [5:0] e_pfx;
    logic [15:0] e_met, e_id;
    logic e_bnd, e_val, ex_m, id_m, lk_m, better;
    logic [1:0] e_ifc;
    logic [5:0] ip;
    logic i_ok_cur, if_m, given_bad, any_bad;
    logic [IdxW-1:0] sel_k;
    t_out_item n_out;
    logic do_write_add, do_del, do_nh, do_if;

    assign e_val = r_valid[r_k];
    assign e_net = r_net[r_k];
    assign e_pfx = r_pfx[r_k];
    assign e_met = r_met[r_k];
    assign e_bnd = r_bnd[r_k];
    assign e_ifc = r_ifc[r_k];
    assign e_id = r_id[r_k];

    assign ex_m = e_val && e_net == r_net_in && e_pfx == r_p_in && e_met == r_in.metric;
    assign id_m = e_val && e_id == r_in.route_id;
    assign lk_m = e_val && !(r_in.iface_given && e_bnd && e_ifc != r_in.iface_index)
        && ((r_in.address ^ e_net) & prefix_mask(e_pfx)) == 32'd0;
    assign better = !r_best_hit || e_pfx > r_best_p
        || (e_pfx == r_best_p && (e_met < r_best_m
        || (e_met == r_best_m && e_id >= r_best_id)));

    function automatic logic iface_ok(input logic [1:0] i, input logic [3:0] en);
        return (int'(i) < NUM_IFACES) && en[i];
    endfunction

    assign ip = sat_prefix(r_if_pfx[6*r_i +: 6]);
    assign i_ok_cur = iface_ok(r_i, r_if_en);
    assign if_m = i_ok_cur && !(r_in.iface_given && r_i != r_in.iface_index)
        && ((r_in.address ^ r_if_addr[r_i]) & prefix_mask(ip)) == 32'd0;
    assign any_bad = !iface_ok(r_in.iface_index, r_if_en);
    assign given_bad = r_in.iface_given && any_bad;

    assign o_sts.scan_last = (int'(r_k) == TABLE_DEPTH - 1);
    assign o_sts.if_last = (int'(r_i) == NUM_IFACES - 1);
    assign o_sts.need_ifscan = (r_in.opcode == OP_LOOKUP) && !r_best_hit && !given_bad;
    assign o_sts.no_result = (r_in.opcode > OP_SET_IF);
    assign o_item = r_out;

    always_comb begin
        n_out = '0;
        sel_k = r_best_k;
        do_write_add = 1'b0;
        do_del = 1'b0;
        do_nh = 1'b0;
        do_if = 1'b0;
        unique case (r_in.opcode)
            OP_ADD: begin
                if (r_ex_hit) begin
                    n_out.status = ST_EXISTS;
                    sel_k = r_ex_k;
                end else if (given_bad) begin
                    n_out.status = ST_BAD_IFACE;
                end else if (!r_free_hit) begin
                    n_out.status = ST_FULL;
                end else begin
                    do_write_add = 1'b1;
                    n_out.result_id = r_next_id;
                    n_out.result_next_hop = r_in.next_hop;
                    n_out.result_has_iface = r_in.iface_given;
                    n_out.result_iface = r_in.iface_given ? r_in.iface_index : 2'd0;
                    n_out.result_prefix = r_p_in;
                    n_out.result_metric = r_in.metric;
                end
            end
            OP_DEL: begin
                sel_k = r_ex_k;
                if (!r_ex_hit) n_out.status = ST_NOT_FOUND;
                else do_del = 1'b1;
            end
            OP_LOOKUP: begin
                if (given_bad) begin
                    n_out.status = ST_BAD_IFACE;
                end else if (r_best_hit) begin
                    n_out.found = 1'b1;
                end else if (r_if_hit) begin
                    n_out.found = 1'b1;
                    n_out.implicit = 1'b1;
                    n_out.result_has_iface = 1'b1;
                    n_out.result_iface = r_if_best;
                    n_out.result_prefix = r_if_p;
                    n_out.result_metric = ImplicitMetric;
                end else begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            OP_SET_NH: begin
                sel_k = r_id_k;
                if (!r_id_hit) n_out.status = ST_NOT_FOUND;
                else do_nh = 1'b1;
            end
            OP_SET_IF: begin
                sel_k = r_id_k;
                if (!r_id_hit) n_out.status = ST_NOT_FOUND;
                else if (any_bad) n_out.status = ST_BAD_IFACE;
                else do_if = 1'b1;
            end
            default: ;
        endcase
        if ((r_in.opcode == OP_ADD && r_ex_hit) || do_del
            || (r_in.opcode == OP_LOOKUP && !given_bad && r_best_hit)) begin
            n_out.result_id = r_id[sel_k];
            n_out.result_next_hop = r_nh[sel_k];
            n_out.result_has_iface = r_bnd[sel_k];
            n_out.result_iface = r_ifc[sel_k];
            n_out.result_prefix = r_pfx[sel_k];
            n_out.result_metric = r_met[sel_k];
        end
        if (do_nh || do_if) begin
            n_out.result_id = r_id[sel_k];
            n_out.result_next_hop = do_nh ? r_in.next_hop : r_nh[sel_k];
            n_out.result_has_iface = do_if ? 1'b1 : r_bnd[sel_k];
            n_out.result_iface = do_if ? r_in.iface_index : r_ifc[sel_k];
            n_out.result_prefix = r_pfx[sel_k];
            n_out.result_metric = r_met[sel_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_next_id <= 16'd1;
            r_if_addr <= '{default: 32'd0};
            r_if_pfx <= '0;
            r_if_en <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IFACE0: r_if_addr[0] <= i_cfg_data;
                    REG_IFACE1: r_if_addr[1] <= i_cfg_data;
                    REG_IFACE2: r_if_addr[2] <= i_cfg_data;
                    REG_IFACE3: r_if_addr[3] <= i_cfg_data;
                    REG_PREFIXES: r_if_pfx <= i_cfg_data[23:0];
                    REG_ENABLES: r_if_en <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                if (do_write_add) begin
                    r_valid[r_free_k] <= 1'b1;
                    r_next_id <= (r_next_id == 16'hFFFF) ? 16'd1 : r_next_id + 16'd1;
                end
                if (do_del) r_valid[sel_k] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
            if (do_write_add) begin
                r_net[r_free_k] <= r_net_in;
                r_pfx[r_free_k] <= r_p_in;
                r_met[r_free_k] <= r_in.metric;
                r_nh[r_free_k] <= r_in.next_hop;
                r_bnd[r_free_k] <= r_in.iface_given;
                r_ifc[r_free_k] <= r_in.iface_given ? r_in.iface_index : 2'd0;
                r_id[r_free_k] <= r_next_id;
            end
            if (do_nh) r_nh[sel_k] <= r_in.next_hop;
            if (do_if) begin
                r_bnd[sel_k] <= 1'b1;
                r_ifc[sel_k] <= r_in.iface_index;
            end
        end
        if (i_cmd.load) begin
            r_in <= i_item;
            r_p_in <= sat_prefix(i_item.prefix_len);
            r_net_in <= i_item.address & prefix_mask(sat_prefix(i_item.prefix_len));
        end
        if (i_cmd.scan_clear) begin
            r_k <= '0;
            r_ex_hit <= 1'b0;
            r_id_hit <= 1'b0;
            r_free_hit <= 1'b0;
            r_best_hit <= 1'b0;
            r_ex_k <= '0;
            r_id_k <= '0;
            r_free_k <= '0;
            r_best_k <= '0;
            r_best_p <= '0;
            r_best_m <= '0;
            r_best_id <= '0;
        end else if (i_cmd.scan_step) begin
            if (!o_sts.scan_last) r_k <= r_k + 1'b1;
            if (ex_m && !r_ex_hit) begin
                r_ex_hit <= 1'b1;
                r_ex_k <= r_k;
            end
            if (id_m && !r_id_hit) begin
                r_id_hit <= 1'b1;
                r_id_k <= r_k;
            end
            if (!e_val && !r_free_hit) begin
                r_free_hit <= 1'b1;
                r_free_k <= r_k;
            end
            if (lk_m && better) begin
                r_best_hit <= 1'b1;
                r_best_k <= r_k;
                r_best_p <= e_pfx;
                r_best_m <= e_met;
                r_best_id <= e_id;
            end
        end
        if (i_cmd.if_clear) begin
            r_i <= '0;
            r_if_hit <= 1'b0;
            r_if_p <= '0;
            r_if_best <= '0;
        end else if (i_cmd.if_step) begin
            if (!o_sts.if_last) r_i <= r_i + 2'd1;
            if (if_m && !(r_if_hit && r_if_p > ip)) begin
                r_if_hit <= 1'b1;
                r_if_p <= ip;
                r_if_best <= r_i;
            end
        end
    end

endmodule

// ===== design/lpm_route_table_core.sv =====
// Channel | Direction | Handshake               | Payload
// input   | in        | i_valid / o_in_stall    | i_in_item (t_in_item)
// output  | out       | o_valid / i_out_stall   | o_out_item (t_out_item)
// config  | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// After acceptance the scan reads one table entry per cycle through all TABLE_DEPTH entries,
// then one interface per cycle through all NUM_IFACES interfaces when a lookup has no table
// match and no bad given interface (the interface scan is passed over otherwise); then the
// result is formed and offered, but an opcode beyond OP_SET_IF yields no result item at all.
// Reset clears every entry valid bit at once and sets the next id to one.
// The input is stalled from acceptance until the cycle after the result item, if any, is taken.
module lpm_route_table_core #(
    parameter int TABLE_DEPTH = lpm_pkg::TableDepth,
    parameter int NUM_IFACES = lpm_pkg::NumIfaces
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    output logic o_in_stall,
    input lpm_pkg::t_in_item i_in_item,
    output logic o_valid,
    input logic i_out_stall,
    output lpm_pkg::t_out_item o_out_item,
    input logic i_cfg_we,
    input logic [lpm_pkg::RegIndexW-1:0] i_cfg_index,
    input logic [31:0] i_cfg_data
);
    import lpm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpm_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_out_stall(i_out_stall),
        .i_sts(sts),
        .o_in_stall(o_in_stall),
        .o_valid(o_valid),
        .o_cmd(cmd)
    );

    lpm_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NUM_IFACES(NUM_IFACES)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_item(i_in_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_cmd(cmd),
        .o_sts(sts),
        .o_item(o_out_item)
    );

endmodule

// ===== tb/tb_lpm_route_table_core.sv =====
module tb_lpm_route_table_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lpm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_we = 1'b0;
    logic [RegIndexW-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    lpm_route_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_valid(o_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [31:0] if_addr [4];
    logic [23:0] if_plens;
    logic [3:0]  if_en;
    logic        rt_valid [TableDepth];
    logic [31:0] rt_net [TableDepth];
    logic [5:0]  rt_plen [TableDepth];
    logic [15:0] rt_metric [TableDepth];
    logic [31:0] rt_nh [TableDepth];
    logic        rt_bound [TableDepth];
    logic [1:0]  rt_if [TableDepth];
    logic [15:0] rt_id [TableDepth];
    logic [15:0] id_counter;

    t_out_item pending_routes[$];
    int errors = 0;
    int ignored_ops = 0;
    logic rx_hold = 1'b0;

    typedef struct {
        t_in_item   item;
        logic       fixed;
        t_out_item  want;
    } t_row;

    function automatic logic [5:0] clamp_plen(input logic [5:0] p);
        return (p > 6'd32) ? 6'd32 : p;
    endfunction

    function automatic logic [31:0] net_mask(input logic [5:0] p);
        return (p == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - p));
    endfunction

    function automatic logic iface_usable(input logic [1:0] i);
        return if_en[i];
    endfunction

    function automatic t_out_item route_fields(input int k, input logic [2:0] st);
        t_out_item r;
        r = '0;
        r.status = st;
        r.result_id = rt_id[k];
        r.result_next_hop = rt_nh[k];
        r.result_has_iface = rt_bound[k];
        r.result_iface = rt_if[k];
        r.result_prefix = rt_plen[k];
        r.result_metric = rt_metric[k];
        return r;
    endfunction

    function automatic int find_route(input logic [31:0] n, input logic [5:0] p,
                                      input logic [15:0] m);
        for (int k = 0; k < TableDepth; k++)
            if (rt_valid[k] && rt_net[k] == n && rt_plen[k] == p && rt_metric[k] == m)
                return k;
        return -1;
    endfunction

    function automatic int find_by_id(input logic [15:0] id);
        for (int k = 0; k < TableDepth; k++)
            if (rt_valid[k] && rt_id[k] == id) return k;
        return -1;
    endfunction

    task automatic route_predict(input t_in_item it, output logic has, output t_out_item r);
        logic [5:0] p;
        logic [31:0] n;
        int k, best, ib;
        logic [5:0] bp, ip;
        p = clamp_plen(it.prefix_len);
        n = it.address & net_mask(p);
        r = '0;
        has = 1'b1;
        best = -1;
        case (it.opcode)
            OP_ADD: begin
                k = find_route(n, p, it.metric);
                if (k >= 0) begin
                    r = route_fields(k, ST_EXISTS);
                end else if (it.iface_given && !iface_usable(it.iface_index)) begin
                    r.status = ST_BAD_IFACE;
                end else begin
                    k = 0;
                    while (k < TableDepth && rt_valid[k]) k++;
                    if (k >= TableDepth) begin
                        r.status = ST_FULL;
                    end else begin
                        rt_valid[k] = 1'b1;
                        rt_net[k] = n;
                        rt_plen[k] = p;
                        rt_metric[k] = it.metric;
                        rt_nh[k] = it.next_hop;
                        rt_bound[k] = it.iface_given;
                        rt_if[k] = it.iface_given ? it.iface_index : 2'd0;
                        rt_id[k] = id_counter;
                        id_counter = (id_counter == 16'hFFFF) ? 16'd1 : id_counter + 16'd1;
                        r = route_fields(k, ST_OK);
                    end
                end
            end
            OP_DEL: begin
                k = find_route(n, p, it.metric);
                if (k < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r = route_fields(k, ST_OK);
                    rt_valid[k] = 1'b0;
                end
            end
            OP_LOOKUP: begin
                if (it.iface_given && !iface_usable(it.iface_index)) begin
                    r.status = ST_BAD_IFACE;
                end else begin
                    for (k = 0; k < TableDepth; k++) begin
                        if (!rt_valid[k]) continue;
                        if (it.iface_given && rt_bound[k] && rt_if[k] != it.iface_index)
                            continue;
                        if (((it.address ^ rt_net[k]) & net_mask(rt_plen[k])) != 0) continue;
                        if (best >= 0) begin
                            if (rt_plen[best] > rt_plen[k]) continue;
                            if (rt_plen[best] == rt_plen[k]) begin
                                if (rt_metric[best] < rt_metric[k]) continue;
                                if (rt_metric[best] == rt_metric[k] && rt_id[best] > rt_id[k])
                                    continue;
                            end
                        end
                        best = k;
                    end
                    if (best >= 0) begin
                        r = route_fields(best, ST_OK);
                        r.found = 1'b1;
                    end else begin
                        ib = -1;
                        bp = 0;
                        for (int i = 0; i < NumIfaces; i++) begin
                            if (!if_en[i]) continue;
                            if (it.iface_given && i != it.iface_index) continue;
                            ip = clamp_plen(if_plens[6*i +: 6]);
                            if (((it.address ^ if_addr[i]) & net_mask(ip)) != 0) continue;
                            if (ib >= 0 && bp > ip) continue;
                            ib = i;
                            bp = ip;
                        end
                        if (ib < 0) begin
                            r.status = ST_NOT_FOUND;
                        end else begin
                            r.found = 1'b1;
                            r.implicit = 1'b1;
                            r.result_has_iface = 1'b1;
                            r.result_iface = ib[1:0];
                            r.result_prefix = bp;
                            r.result_metric = ImplicitMetric;
                        end
                    end
                end
            end
            OP_SET_NH: begin
                k = find_by_id(it.route_id);
                if (k < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    rt_nh[k] = it.next_hop;
                    r = route_fields(k, ST_OK);
                end
            end
            OP_SET_IF: begin
                k = find_by_id(it.route_id);
                if (k < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (!iface_usable(it.iface_index)) begin
                    r.status = ST_BAD_IFACE;
                end else begin
                    rt_bound[k] = 1'b1;
                    rt_if[k] = it.iface_index;
                    r = route_fields(k, ST_OK);
                end
            end
            default: has = 1'b0;
        endcase
    endtask

    task automatic write_reg(input logic [RegIndexW-1:0] idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IFACE0, REG_IFACE1, REG_IFACE2, REG_IFACE3: if_addr[idx[1:0]] = v;
            REG_PREFIXES: if_plens = v[23:0];
            REG_ENABLES: if_en = v[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (TableDepth + NumIfaces + 8) @(posedge i_clk);
    endtask

    task automatic send_route_op(input t_in_item it, input logic fixed, input t_out_item want,
                                 input int gap);
        logic has;
        t_out_item r;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        route_predict(it, has, r);
        if (has) begin
            if (fixed && r !== want) begin
                $error("table row differs from predictor: expected %h got %h", want, r);
                errors++;
            end
            pending_routes.push_back(fixed ? want : r);
        end
    endtask

    function automatic t_in_item rand_route_op(input int mode);
        t_in_item it;
        it.opcode = t_opcode'($urandom_range(0, 99) < 3 ? $urandom_range(5, 7) :
                              $urandom_range(0, 4));
        it.address = $urandom();
        if (mode == 0) it.address = {8'd10, 22'd0, 2'(it.address)} | ($urandom_range(0, 3) << 8);
        it.prefix_len = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 32));
        if (mode == 0 && $urandom_range(0, 1)) it.prefix_len = 6'($urandom_range(8, 24));
        it.metric = (mode == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom());
        it.next_hop = $urandom();
        it.iface_given = 1'($urandom_range(0, 1));
        it.iface_index = 2'($urandom_range(0, 3));
        it.route_id = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                      16'(id_counter - $urandom_range(1, 20));
        return it;
    endfunction

    function automatic t_in_item mk(input t_opcode op, input logic [31:0] a, input logic [5:0] p,
                                    input logic [15:0] m, input logic [31:0] nh,
                                    input logic g, input logic [1:0] ix, input logic [15:0] id);
        t_in_item it;
        it.opcode = op; it.address = a; it.prefix_len = p; it.metric = m;
        it.next_hop = nh; it.iface_given = g; it.iface_index = ix; it.route_id = id;
        return it;
    endfunction

    // Output side: random stall per item.
    initial begin
        int w;
        forever begin
            w = $urandom_range(0, 6);
            if (w != 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            while (rx_hold) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_valid && !i_out_stall) begin
            if (pending_routes.size() == 0) begin
                $error("result item with no expectation: %h", o_out_item);
                errors++;
            end else begin
                w = pending_routes.pop_front();
                if (o_out_item.status !== w.status) begin
                    $error("status expected %0d got %0d", w.status, o_out_item.status); errors++;
                end
                if (o_out_item.found !== w.found) begin
                    $error("found expected %0d got %0d", w.found, o_out_item.found); errors++;
                end
                if (o_out_item.implicit !== w.implicit) begin
                    $error("implicit expected %0d got %0d", w.implicit, o_out_item.implicit);
                    errors++;
                end
                if (o_out_item.result_id !== w.result_id) begin
                    $error("result_id expected %0d got %0d", w.result_id, o_out_item.result_id);
                    errors++;
                end
                if (o_out_item.result_next_hop !== w.result_next_hop) begin
                    $error("result_next_hop expected %h got %h", w.result_next_hop,
                           o_out_item.result_next_hop); errors++;
                end
                if (o_out_item.result_has_iface !== w.result_has_iface) begin
                    $error("result_has_iface expected %0d got %0d", w.result_has_iface,
                           o_out_item.result_has_iface); errors++;
                end
                if (o_out_item.result_iface !== w.result_iface) begin
                    $error("result_iface expected %0d got %0d", w.result_iface,
                           o_out_item.result_iface); errors++;
                end
                if (o_out_item.result_prefix !== w.result_prefix) begin
                    $error("result_prefix expected %0d got %0d", w.result_prefix,
                           o_out_item.result_prefix); errors++;
                end
                if (o_out_item.result_metric !== w.result_metric) begin
                    $error("result_metric expected %0d got %0d", w.result_metric,
                           o_out_item.result_metric); errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_out_item z;
        t_in_item it;
        for (int i = 0; i < 4; i++) if_addr[i] = '0;
        if_plens = '0;
        if_en = '0;
        for (int k = 0; k < TableDepth; k++) begin
            rt_valid[k] = 0; rt_net[k] = 0; rt_plen[k] = 0; rt_metric[k] = 0;
            rt_nh[k] = 0; rt_bound[k] = 0; rt_if[k] = 0; rt_id[k] = 0;
        end
        id_counter = 16'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed rows; fixed expectations only where obvious.
        z = '0;
        row.fixed = 1'b1; row.want = z; row.want.status = ST_NOT_FOUND;
        row.item = mk(OP_LOOKUP, 32'h0A000001, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_DEL, 32'hFFFFFFFF, 32, 16'hFFFF, 0, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_SET_NH, 0, 0, 0, 32'h1, 0, 0, 16'd1); rows.push_back(row);
        row.item = mk(OP_SET_IF, 0, 0, 0, 0, 0, 2, 16'hFFFF); rows.push_back(row);
        row.want.status = ST_BAD_IFACE;
        row.item = mk(OP_ADD, 32'h01020304, 8, 5, 0, 1, 3, 0); rows.push_back(row);
        row.item = mk(OP_LOOKUP, 32'h01020304, 8, 5, 0, 1, 0, 0); rows.push_back(row);
        row.fixed = 1'b0;
        row.item = mk(OP_ADD, 32'hFFFFFFFF, 63, 16'hFFFF, 32'hFFFFFFFF, 0, 3, 0); rows.push_back(row);
        row.item = mk(OP_ADD, 32'hFFFFFFFF, 32, 16'hFFFF, 32'h1, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_ADD, 32'hDEADBEEF, 0, 0, 32'h5, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_ADD, 32'h0A0B0C0D, 16, 7, 32'h7, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_ADD, 32'h0A0BFFFF, 16, 3, 32'h8, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_LOOKUP, 32'h0A0B0001, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_LOOKUP, 32'h12345678, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = mk(OP_SET_NH, 0, 0, 0, 32'hCAFEF00D, 0, 0, 16'd2); rows.push_back(row);
        row.item = mk(OP_SET_IF, 0, 0, 0, 0, 0, 1, 16'd2); rows.push_back(row);
        row.item = mk(OP_DEL, 32'h0A0B0000, 16, 3, 0, 0, 0, 0); rows.push_back(row);
        row.item = mk(t_opcode'(3'd7), 32'h1, 1, 1, 1, 1, 1, 1); rows.push_back(row);
        foreach (rows[i]) send_route_op(rows[i].item, rows[i].fixed, rows[i].want,
                                        $urandom_range(0, 6));
        wait_drained();

        // Interfaces: overlapping subnets, tie, saturated prefix.
        write_reg(REG_IFACE0, 32'h0A000001);
        write_reg(REG_IFACE1, 32'h0A0B0001);
        write_reg(REG_IFACE2, 32'h0A0B0002);
        write_reg(REG_IFACE3, 32'hFFFFFFFF);
        write_reg(REG_PREFIXES, {6'd63, 6'd16, 6'd16, 6'd8});
        write_reg(REG_ENABLES, 4'hF);
        send_route_op(mk(OP_LOOKUP, 32'h0A0B7777, 0, 0, 0, 0, 0, 0), 0, z, 0);
        send_route_op(mk(OP_LOOKUP, 32'h0A0B7777, 0, 0, 0, 1, 1, 0), 0, z, 1);
        send_route_op(mk(OP_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 1, 3, 0), 0, z, 2);
        send_route_op(mk(OP_ADD, 32'h0A0B0C00, 24, 1, 32'h9, 1, 2, 0), 0, z, 0);
        send_route_op(mk(OP_LOOKUP, 32'h0A0B0C01, 0, 0, 0, 1, 1, 0), 0, z, 0);
        wait_drained();

        // Fill the table under a long receiver hold.
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            for (int n = 0; n < 24; n++)
                send_route_op(mk(OP_ADD, $urandom(), 6'($urandom_range(0, 32)), 16'(n), $urandom(),
                                 0, 0, 0), 0, z, 0);
        join
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            for (int r = 0; r < 4; r++) write_reg(r[2:0], $urandom());
            write_reg(REG_PREFIXES, (phase == 3) ? 32'hFFFFFF :
                      (phase == 2) ? 32'h0 : $urandom());
            write_reg(REG_ENABLES, (phase == 2) ? 4'h0 : (phase == 3) ? 4'hF : $urandom());
            if (phase == 1) write_reg(REG_IFACE0, 32'h0A000000);
            for (int n = 0; n < 200; n++) begin
                it = rand_route_op((n % 4 == 3) ? 1 : 0);
                if (it.opcode > 3'd4) ignored_ops++;
                send_route_op(it, 0, z, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6));
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
